/* hdl/psched_pkg.sv */
// Shared types, constants and helpers for the preemptive priority scheduler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package psched_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // One queued request as classified by the front end.
    typedef struct packed {
        logic       is_admit;
        logic       burst_zero;
        logic [7:0] prio;
        logic [9:0] burst;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  assigned_id;
        logic        cpu_idle;
        logic [2:0]  running_id;
        logic        context_switch;
        logic        finished;
        logic [15:0] start_stamp;
        logic [15:0] turnaround;
        logic [15:0] waiting;
    } t_result;

    // Reported slot numbers carry only the low three bits of the index.
    function automatic logic [2:0] slot_id(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+2:0] ext;
        ext = {3'b000, idx};
        return ext[2:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/psched_front.sv */
// Front end of the scheduler: takes requests, classifies them and queues
// them for the back end in a two-entry queue. Uses psched_pkg.
`default_nettype none

module psched_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire                   i_action,
    input  wire  [7:0]            i_proc_priority,
    input  wire  [9:0]            i_proc_burst,
    output logic                  o_q_valid,
    output psched_pkg::t_item     o_q_item,
    input  wire                   i_q_pop
);
    import psched_pkg::*;

    localparam int QDEPTH = 2;

    t_item            r_mem [QDEPTH];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             push;
    logic             pop;
    t_item            n_item;

    assign o_ready   = (r_cnt != 2'(QDEPTH));
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_item.is_admit   = i_action;
        n_item.burst_zero = (i_proc_burst == 10'd0);
        n_item.prio       = i_proc_priority;
        n_item.burst      = i_proc_burst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_mem[r_wp] <= n_item;
                r_wp        <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/psched_back.sv */
// Back end of the scheduler: slot table, one-comparator priority scan and
// the result register. Uses psched_pkg; fed by psched_front.
`default_nettype none

module psched_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_q_valid,
    input  psched_pkg::t_item     i_q_item,
    output logic                  o_q_pop,
    output logic                  o_res_valid,
    output psched_pkg::t_result   o_res,
    input  wire                   i_res_ready
);
    import psched_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ADMIT, S_SCAN, S_EXEC} t_state;

    t_state              r_state;
    t_item               r_item;
    t_result             r_out;
    logic                r_out_valid;

    // Slot table
    logic [SLOTS-1:0]    r_valid;
    logic [SLOTS-1:0]    r_has_run;
    logic [7:0]          r_prio  [SLOTS];
    logic [9:0]          r_rem   [SLOTS];
    logic [9:0]          r_len   [SLOTS];
    logic [15:0]         r_arr   [SLOTS];
    logic [15:0]         r_first [SLOTS];

    logic [SLOT_W-1:0]   r_cur_slot;
    logic                r_cur_valid;
    logic [15:0]         r_time;
    logic [CNT_W-1:0]    r_count;

    // Scan position and the best candidate seen so far
    logic [SLOT_W-1:0]   r_idx;
    logic                r_found;
    logic [SLOT_W-1:0]   r_best;
    logic [7:0]          r_bprio;
    logic [9:0]          r_brem;
    logic [9:0]          r_blen;
    logic [15:0]         r_barr;
    logic [15:0]         r_bfirst;
    logic                r_bhas;

    logic                out_free;
    logic                res_load;
    logic                eligible;
    logic                take;
    logic                full;
    logic [SLOT_W-1:0]   new_idx;
    logic [9:0]          n_rem;
    logic                fin;
    logic [15:0]         n_first;
    logic [15:0]         n_ta;
    logic [15:0]         n_wait;
    t_result             n_admit_res;
    t_result             n_tick_res;

    assign out_free    = !r_out_valid || i_res_ready;
    assign res_load    = out_free && ((r_state == S_ADMIT) || (r_state == S_EXEC));
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // A candidate replaces the best on a strictly lower priority value, or on an
    // equal value when it is the slot that ran last; otherwise the lowest index stays.
    assign eligible = r_valid[r_idx] && (r_rem[r_idx] != 10'd0);
    assign take     = eligible && (!r_found || (r_prio[r_idx] < r_bprio) ||
                      ((r_prio[r_idx] == r_bprio) && r_cur_valid && (r_idx == r_cur_slot)));

    assign full     = (r_count == CNT_W'(SLOTS));
    assign new_idx  = r_count[SLOT_W-1:0];

    assign n_rem    = r_brem - 10'd1;
    assign fin      = (n_rem == 10'd0);
    assign n_first  = r_bhas ? r_bfirst : r_time;
    assign n_ta     = r_time + 16'd1 - r_barr;
    assign n_wait   = n_ta - 16'(r_blen);

    always_comb begin
        n_admit_res = '0;
        if (full) begin
            n_admit_res.status = ST_FULL;
        end else if (r_item.burst_zero) begin
            n_admit_res.status = ST_ZERO;
        end else begin
            n_admit_res.status      = ST_OK;
            n_admit_res.assigned_id = slot_id(new_idx);
        end

        n_tick_res = '0;
        if (!r_found) begin
            n_tick_res.cpu_idle = 1'b1;
        end else begin
            n_tick_res.running_id     = slot_id(r_best);
            n_tick_res.context_switch = !r_cur_valid || (r_cur_slot != r_best);
            n_tick_res.finished       = fin;
            if (fin) begin
                n_tick_res.start_stamp = n_first;
                n_tick_res.turnaround  = n_ta;
                n_tick_res.waiting     = n_wait;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_has_run   <= '0;
            r_cur_slot  <= '0;
            r_cur_valid <= 1'b0;
            r_time      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
        end else begin
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_item;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_state <= i_q_item.is_admit ? S_ADMIT : S_SCAN;
                    end
                end
                S_ADMIT: begin
                    if (out_free) begin
                        r_out <= n_admit_res;
                        if (!full && !r_item.burst_zero) begin
                            r_valid[new_idx]   <= 1'b1;
                            r_has_run[new_idx] <= 1'b0;
                            r_prio[new_idx]    <= r_item.prio;
                            r_rem[new_idx]     <= r_item.burst;
                            r_len[new_idx]     <= r_item.burst;
                            r_arr[new_idx]     <= r_time;
                            r_count            <= r_count + CNT_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (take) begin
                        r_found  <= 1'b1;
                        r_best   <= r_idx;
                        r_bprio  <= r_prio[r_idx];
                        r_brem   <= r_rem[r_idx];
                        r_blen   <= r_len[r_idx];
                        r_barr   <= r_arr[r_idx];
                        r_bfirst <= r_first[r_idx];
                        r_bhas   <= r_has_run[r_idx];
                    end
                    r_idx <= r_idx + SLOT_W'(1);
                    if (r_idx == SLOT_W'(SLOTS - 1)) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_out <= n_tick_res;
                        if (r_found) begin
                            r_rem[r_best] <= n_rem;
                            if (!r_bhas) begin
                                r_first[r_best]   <= r_time;
                                r_has_run[r_best] <= 1'b1;
                            end
                            r_cur_slot  <= r_best;
                            r_cur_valid <= !fin;
                        end
                        r_time  <= r_time + 16'd1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/preemptive_priority_scheduler_core.sv */
// Top level of the preemptive priority scheduler: front-end request queue
// and back-end executor. Uses psched_pkg, psched_front and psched_back.
`default_nettype none

// Each request returns exactly one result. An admit is taken from the queue,
// then writes its slot and loads the result register. A tick is taken from
// the queue, scans the slots in turn for the best priority through a single
// comparator, then updates the chosen slot and loads the result register.
// Both final steps wait while a result is stalled. A two-entry queue in
// front accepts new requests while the back end works or a result is stalled.
module preemptive_priority_scheduler_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_action,
    input  wire  [7:0]  i_proc_priority,
    input  wire  [9:0]  i_proc_burst,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_status,
    output logic [2:0]  o_assigned_id,
    output logic        o_cpu_idle,
    output logic [2:0]  o_running_id,
    output logic        o_context_switch,
    output logic        o_finished,
    output logic [15:0] o_start_stamp,
    output logic [15:0] o_turnaround,
    output logic [15:0] o_waiting
);
    import psched_pkg::*;

    logic    q_valid;
    t_item   q_item;
    logic    q_pop;
    t_result res;

    psched_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_proc_priority (i_proc_priority),
        .i_proc_burst    (i_proc_burst),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    psched_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_res_valid (o_valid),
        .o_res       (res),
        .i_res_ready (i_ready)
    );

    assign o_status         = res.status;
    assign o_assigned_id    = res.assigned_id;
    assign o_cpu_idle       = res.cpu_idle;
    assign o_running_id     = res.running_id;
    assign o_context_switch = res.context_switch;
    assign o_finished       = res.finished;
    assign o_start_stamp    = res.start_stamp;
    assign o_turnaround     = res.turnaround;
    assign o_waiting        = res.waiting;

`ifndef NO_ASSERTIONS
    a_reject_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_assigned_id == 3'd0))
        else $error("rejected request carries a slot number");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cpu_idle) |-> (!o_context_switch && !o_finished))
        else $error("idle tick reports a switch or a completion");

    a_admit_no_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (!o_cpu_idle && !o_finished))
        else $error("rejected admit carries tick fields");
`endif

endmodule

`default_nettype wire
